@@ src/tod_pkg.sv @@
// Shared types and constants for the tilt orientation debouncer.
// Used by the front, queue, back and top-level modules; no dependencies.
package tod_pkg;

	// Default widths for the top-level parameters
	localparam int ACCEL_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed register widths
	localparam int ROT_W    = 2;
	localparam int THRESH_W = 32;
	localparam int STABLE_W = 16;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Decoupling queue depth
	localparam int QUEUE_DEPTH = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_MS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE   = 2'd3;

	// Register reset values
	localparam logic [ROT_W-1:0]    ROT_OFFSET_RST = 2'd0;
	localparam logic [THRESH_W-1:0] LEVEL_THR_RST  = 32'd505892;
	localparam logic [STABLE_W-1:0] STABLE_MS_RST  = 16'd200;
	localparam logic [ROT_W-1:0]    BASELINE_RST   = 2'd0;

	// Rotation codes
	localparam logic [ROT_W-1:0] ROT_PORTRAIT   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_LANDSCAPE  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_INVERTED   = 2'd2;
	localparam logic [ROT_W-1:0] ROT_INV_LANDSC = 2'd3;

	// Live configuration seen by the datapath
	typedef struct packed {
		logic [ROT_W-1:0]    rot_offset;
		logic [THRESH_W-1:0] level_thr;
		logic [STABLE_W-1:0] persist_ms;
	} cfg_t;

	// Baseline load request toward the back part
	typedef struct packed {
		logic             load;
		logic [ROT_W-1:0] rot;
	} base_load_t;

endpackage

@@ src/tod_front.sv @@
// Front part: takes samples, squares the axes, applies the dead zone and
// picks the quarter-turn candidate. Depends on tod_pkg.
module tod_front #(
	parameter int ACCEL_BITS = tod_pkg::ACCEL_BITS_DEF,
	parameter int TIME_BITS  = tod_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tod_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_sample_valid,
	input  logic signed [ACCEL_BITS-1:0]  in_accel_x,
	input  logic signed [ACCEL_BITS-1:0]  in_accel_y,
	input  logic [TIME_BITS-1:0]          in_now_ms,
	input  logic [$clog2(tod_pkg::QUEUE_DEPTH+1)-1:0] q_level,
	output logic                          push,
	output logic [tod_pkg::ROT_W-1:0]     push_cand,
	output logic [TIME_BITS-1:0]          push_now
);
	import tod_pkg::*;

	localparam int MAG_W = ACCEL_BITS + 1;
	localparam int SQ_W  = 2 * ACCEL_BITS;
	localparam int CMP_W = (SQ_W > THRESH_W) ? SQ_W : THRESH_W;
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic signed [MAG_W-1:0] xe, ye;
	logic [MAG_W-1:0]        mx, my;
	logic                    xp, yp;
	logic [ROT_W-1:0]        cand;
	logic [2*MAG_W-1:0]      sqx_full, sqy_full;
	logic                    accept;

	logic                    valid_s1;
	logic [SQ_W-1:0]         sqx_s1, sqy_s1;
	logic [ROT_W-1:0]        cand_s1;
	logic [TIME_BITS-1:0]    now_s1;
	logic [SQ_W-1:0]         sum;

	// Accept only when the queue can hold this item and the one in flight
	assign in_ready = ((LVL_W+1)'(q_level) + (LVL_W+1)'(valid_s1)) < (LVL_W+1)'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;

	// Split each axis into magnitude and strict-positive flag
	always_comb begin
		xe = MAG_W'(in_accel_x);
		ye = MAG_W'(in_accel_y);
		mx = xe[MAG_W-1] ? unsigned'(-xe) : unsigned'(xe);
		my = ye[MAG_W-1] ? unsigned'(-ye) : unsigned'(ye);
		xp = !in_accel_x[ACCEL_BITS-1] && (in_accel_x != '0);
		yp = !in_accel_y[ACCEL_BITS-1] && (in_accel_y != '0);
		// Larger axis wins, a tie goes to Y
		if (mx > my) begin
			cand = xp ? ROT_INV_LANDSC : ROT_LANDSCAPE;
		end else begin
			cand = yp ? ROT_PORTRAIT : ROT_INVERTED;
		end
		sqx_full = mx * mx;
		sqy_full = my * my;
	end

	// Stage 1 valid: drop samples flagged unusable here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && in_sample_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sqx_s1  <= sqx_full[SQ_W-1:0];
			sqy_s1  <= sqy_full[SQ_W-1:0];
			cand_s1 <= cand;
			now_s1  <= in_now_ms;
		end
	end

	// Dead zone: strictly below the threshold is dropped
	assign sum       = sqx_s1 + sqy_s1;
	assign push      = valid_s1 && (CMP_W'(sum) >= CMP_W'(cfg.level_thr));
	assign push_cand = cand_s1;
	assign push_now  = now_s1;

endmodule

@@ src/tod_queue.sv @@
// Short FIFO between the front and back parts.
// Depends on tod_pkg for the depth.
module tod_queue #(
	parameter int WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data,
	output logic [$clog2(tod_pkg::QUEUE_DEPTH+1)-1:0] level
);
	import tod_pkg::*;

	localparam int AW    = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = mem[rd_ptr_q];
	assign level      = count_q;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/tod_back.sv @@
// Back part: candidate tracking, stability timer and result register.
// Depends on tod_pkg.
module tod_back #(
	parameter int TIME_BITS = tod_pkg::TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tod_pkg::cfg_t             cfg,
	input  tod_pkg::base_load_t       base,
	input  logic                      head_valid,
	input  logic [tod_pkg::ROT_W-1:0] head_cand,
	input  logic [TIME_BITS-1:0]      head_now,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tod_pkg::ROT_W-1:0] out_logical,
	output logic [tod_pkg::ROT_W-1:0] out_display
);
	import tod_pkg::*;

	logic [ROT_W-1:0]     applied_q, cand_q;
	logic [TIME_BITS-1:0] since_q;
	logic                 out_valid_q;
	logic [ROT_W-1:0]     logical_q, display_q;
	logic [TIME_BITS-1:0] elapsed;
	logic                 cand_same, fire;

	// Take an entry whenever the result register is free or draining
	assign pop = head_valid && (!out_valid_q || out_ready);

	// A changed candidate restarts the timer, so it can never fire this step
	assign cand_same = (head_cand == cand_q);
	assign elapsed   = head_now - since_q;
	assign fire      = pop && cand_same && (head_cand != applied_q)
		&& (elapsed > TIME_BITS'(cfg.persist_ms));

	// Orientation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q <= BASELINE_RST;
			cand_q    <= BASELINE_RST;
			since_q   <= '0;
		end else if (base.load) begin
			applied_q <= base.rot;
			cand_q    <= base.rot;
		end else if (pop) begin
			if (!cand_same) begin
				cand_q  <= head_cand;
				since_q <= head_now;
			end
			if (fire) begin
				applied_q <= head_cand;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			logical_q <= head_cand;
			display_q <= head_cand + cfg.rot_offset;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_logical = logical_q;
	assign out_display = display_q;

endmodule

@@ src/tilt_orientation_debouncer_core.sv @@
// Tilt orientation debouncer, top level.
// Throughput: one sample per cycle while s_tready is high. A result reaches
// m_tvalid through the square stage, the queue and the result register.
// Backpressure on the result port stalls input once the 4-entry queue and the
// square stage together hold four samples.
// Reset (arst_n, asynchronous): registers take their defaults, applied and
// candidate rotation take the reset baseline, the queue and result are empty.
module tilt_orientation_debouncer_core #(
	parameter int ACCEL_BITS = tod_pkg::ACCEL_BITS_DEF,
	parameter int TIME_BITS  = tod_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tod_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tod_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// accel_x, accel_y, now_ms, zero fill
	input  logic [((2*ACCEL_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// sample_valid
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// logical_rotation, display_rotation, zero fill
	output logic [7:0]                      m_tdata
);
	import tod_pkg::*;

	localparam int QW = ROT_W + TIME_BITS;

	cfg_t                  cfg_q;
	base_load_t            base;
	logic                  push, pop, head_valid;
	logic [ROT_W-1:0]      push_cand, out_logical, out_display;
	logic [TIME_BITS-1:0]  push_now;
	logic [QW-1:0]         head_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_offset <= ROT_OFFSET_RST;
			cfg_q.level_thr  <= LEVEL_THR_RST;
			cfg_q.persist_ms <= STABLE_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROT_OFFSET: cfg_q.rot_offset <= cfg_data[ROT_W-1:0];
				CFG_LEVEL_THR:  cfg_q.level_thr  <= cfg_data[THRESH_W-1:0];
				CFG_STABLE_MS:  cfg_q.persist_ms <= cfg_data[STABLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Baseline write reloads the orientation state in the back part
	assign base.load = cfg_we && (cfg_index == CFG_BASELINE);
	assign base.rot  = cfg_data[ROT_W-1:0];

	tod_front #(
		.ACCEL_BITS(ACCEL_BITS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_sample_valid(s_tuser[0]),
		.in_accel_x     (s_tdata[ACCEL_BITS-1:0]),
		.in_accel_y     (s_tdata[2*ACCEL_BITS-1:ACCEL_BITS]),
		.in_now_ms      (s_tdata[2*ACCEL_BITS+TIME_BITS-1:2*ACCEL_BITS]),
		.q_level        (q_level),
		.push           (push),
		.push_cand      (push_cand),
		.push_now       (push_now)
	);

	tod_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_now, push_cand}),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data),
		.level     (q_level)
	);

	tod_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.base       (base),
		.head_valid (head_valid),
		.head_cand  (head_data[ROT_W-1:0]),
		.head_now   (head_data[QW-1:ROT_W]),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_logical(out_logical),
		.out_display(out_display)
	);

	assign m_tdata = {4'b0000, out_display, out_logical};

endmodule
